FILE: rtl/core/partial_ipv4_address_parser_macros.svh
// Assertion macros shared by the partial IPv4 address parser RTL.
`ifndef PARTIAL_IPV4_ADDRESS_PARSER_MACROS_SVH
`define PARTIAL_IPV4_ADDRESS_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PIA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pia_pkg.sv
// Types and constants for the partial IPv4 address parser.
`default_nettype none

package pia_pkg;

  // Parse phase of the current string
  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_GROUP     = 3'd1,
    PH_PORT_WS   = 3'd2,
    PH_PORT_DIG  = 3'd3,
    PH_PORT_DONE = 3'd4,
    PH_ADDR_DONE = 3'd5,
    PH_ERROR     = 3'd6
  } phase_t;

  // Per-string parse state
  typedef struct packed {
    phase_t      phase;
    logic [9:0]  group_value;
    logic [1:0]  digit_run;
    logic [31:0] address_acc;
    logic [2:0]  group_count;
    logic        error_seen;
    logic [15:0] port_acc;
    logic        port_negative;
  } parse_state_t;

  // Configuration register indexes
  localparam logic CFG_LOCAL_ADDRESS = 1'b0;
  localparam logic CFG_DEFAULT_PORT  = 1'b1;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_COLON = 8'd58;

  // Group limits
  localparam logic [9:0] GROUP_MAX  = 10'd255;
  localparam logic [1:0] DIGITS_MAX = 2'd3;
  localparam logic [2:0] GROUPS_MAX = 3'd4;

  localparam parse_state_t STATE_CLEAR = '{
    phase:         PH_START,
    group_value:   10'd0,
    digit_run:     2'd0,
    address_acc:   32'd0,
    group_count:   3'd0,
    error_seen:    1'b0,
    port_acc:      16'd0,
    port_negative: 1'b0
  };

endpackage

`default_nettype wire

FILE: rtl/core/partial_ipv4_address_parser.sv
// A character marked last gives its result on out_* in the cycle after it is accepted.
// Throughput: one character per cycle while in_tready is high; the parse state register is updated in one pass.
// in_tready drops only while an unclaimed result sits in the output register.
// Reset (synchronous, rst_n low) clears the parse state, the output valid and both
// configuration registers; no clearing pass is needed.
`default_nettype none
`include "partial_ipv4_address_parser_macros.svh"

module partial_ipv4_address_parser
  import pia_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  // character stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // last
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] address, [47:32] port
  output logic             out_tuser   // [0] status
);

  logic [31:0]  local_address_r;
  logic [15:0]  default_port_r;
  parse_state_t st_r, st_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [47:0]  out_data_r, out_data_nxt;
  logic         out_status_r, out_status_nxt;
  logic         in_acc;

  // Close the current group: range check, shift into the address, count it
  function automatic parse_state_t close_group(parse_state_t s);
    parse_state_t r;
    r = s;
    if (s.group_value > GROUP_MAX) begin
      r.error_seen = 1'b1;
      r.phase      = PH_ERROR;
    end else begin
      r.address_acc = {s.address_acc[23:0], s.group_value[7:0]};
      if (s.group_count < GROUPS_MAX) begin
        r.group_count = s.group_count + 3'd1;
      end
      r.group_value = 10'd0;
      r.digit_run   = 2'd0;
    end
    return r;
  endfunction

  // One character in the address part
  function automatic parse_state_t group_char(parse_state_t s, logic [7:0] c);
    parse_state_t r;
    logic [9:0]   d;
    r = s;
    d = {2'b00, c - CH_ZERO};
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      if (s.digit_run >= DIGITS_MAX) begin
        r.error_seen = 1'b1;
        r.phase      = PH_ERROR;
      end else begin
        r.digit_run   = s.digit_run + 2'd1;
        r.group_value = (s.group_value << 3) + (s.group_value << 1) + d;
      end
    end else if (c == CH_DOT) begin
      r = close_group(s);
    end else if (c == CH_COLON) begin
      r = close_group(s);
      if (r.phase != PH_ERROR) begin
        r.phase = PH_PORT_WS;
      end
    end else if (c == CH_NUL) begin
      r = close_group(s);
      if (r.phase != PH_ERROR) begin
        r.phase = PH_ADDR_DONE;
      end
    end else begin
      r.error_seen = 1'b1;
      r.phase      = PH_ERROR;
    end
    return r;
  endfunction

  // Accept while the output register is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Parse one character and form the result on the last one
  always_comb begin
    parse_state_t s;
    logic [7:0]   c;
    logic [15:0]  pd;
    logic [31:0]  mask;
    logic [15:0]  port_val;
    c        = in_tdata;
    pd       = {8'd0, c - CH_ZERO};
    s        = st_r;
    mask     = 32'd0;
    port_val = 16'd0;

    case (s.phase)
      PH_START: begin
        s.phase = PH_GROUP;
        if (c != CH_DOT) begin
          s = group_char(s, c);
        end
      end
      PH_GROUP: begin
        s = group_char(s, c);
      end
      PH_PORT_WS: begin
        if (c inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
          s.phase = PH_PORT_WS;
        end else if (c == CH_MINUS) begin
          s.port_negative = 1'b1;
          s.phase         = PH_PORT_DIG;
        end else if (c == CH_PLUS) begin
          s.phase = PH_PORT_DIG;
        end else if (c inside {[CH_ZERO:CH_NINE]}) begin
          s.port_acc = (s.port_acc << 3) + (s.port_acc << 1) + pd;
          s.phase    = PH_PORT_DIG;
        end else begin
          s.phase = PH_PORT_DONE;
        end
      end
      PH_PORT_DIG: begin
        if (c inside {[CH_ZERO:CH_NINE]}) begin
          s.port_acc = (s.port_acc << 3) + (s.port_acc << 1) + pd;
        end else begin
          s.phase = PH_PORT_DONE;
        end
      end
      default: begin
        s.phase = st_r.phase;
      end
    endcase

    // Close an open group at the end of the string
    if (in_tlast && s.phase == PH_GROUP) begin
      s = close_group(s);
    end

    if (s.group_count < GROUPS_MAX) begin
      mask = 32'hFFFF_FFFF << {s.group_count[1:0], 3'b000};
    end
    if (s.phase == PH_PORT_WS || s.phase == PH_PORT_DIG || s.phase == PH_PORT_DONE) begin
      port_val = s.port_negative ? (16'd0 - s.port_acc) : s.port_acc;
    end else begin
      port_val = default_port_r;
    end

    if (s.error_seen) begin
      out_status_nxt = 1'b1;
      out_data_nxt   = 48'd0;
    end else begin
      out_status_nxt = 1'b0;
      out_data_nxt   = {port_val, (local_address_r & mask) | s.address_acc};
    end

    st_nxt = in_tlast ? STATE_CLEAR : s;

    // Hold the result until taken
    if (in_acc && in_tlast) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Parse state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= 32'd0;
      default_port_r  <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_ADDRESS: local_address_r <= cfg_wdata;
        CFG_DEFAULT_PORT:  default_port_r  <= cfg_wdata[15:0];
        default:           local_address_r <= local_address_r;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // Checks
  `PIA_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid_r && out_status_r, out_data_r == 48'd0, "error result carries payload")
  `PIA_ASSERT_NEXT(a_last_result, clk, rst_n, in_acc && in_tlast, out_valid_r, "last item gave no result")
  `PIA_ASSERT_NEXT(a_mid_quiet, clk, rst_n, in_acc && !in_tlast, !out_valid_r, "result without last item")
  `PIA_ASSERT_NEXT(a_last_clear, clk, rst_n, in_acc && in_tlast, st_r.phase == PH_START, "state not cleared")
  `PIA_ASSERT_IMPL(a_count_sat, clk, rst_n, 1'b1, st_r.group_count <= GROUPS_MAX, "group count past limit")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Testbench for the partial IPv4 address parser: directed and random strings checked against a predictor.
module testbench;
  import pia_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic        status;
    logic [31:0] address;
    logic [15:0] port;
  } parse_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = CFG_LOCAL_ADDRESS;
  logic [31:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] char_code
  logic        in_tlast   = 1'b0; // last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // [31:0] address, [47:32] port
  logic        out_tuser;         // [0] status

  // Predictor copy of the registers and of the string state
  logic [31:0] local_addr_q   = '0;
  logic [15:0] default_port_q = '0;
  phase_t      ph;
  logic [9:0]  grp_val;
  logic [1:0]  digit_run;
  logic [31:0] addr_acc;
  logic [2:0]  grp_count;
  logic        err_seen;
  logic [15:0] port_acc;
  logic        port_neg;

  parse_result_t pending_parses[$];
  logic [7:0]    text[$];
  int            mismatches = 0;
  int            chars_sent = 0;
  bit            idle_gaps  = 1'b1;
  bit            ready_gaps = 1'b1;
  bit            hold_req   = 1'b0;

  partial_ipv4_address_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] space_char();
    int r;
    r = $urandom_range(0, 6);
    return (r == 6) ? CH_SPACE : 8'(CH_TAB + r);
  endfunction

  // Any byte half the time, otherwise one the parser treats specially
  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 15))
      0: return CH_NUL;
      1: return CH_DOT;
      2: return CH_COLON;
      3: return CH_PLUS;
      4: return CH_MINUS;
      5: return space_char();
      6, 7: return rand_digit();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void restart_string();
    ph        = PH_START;
    grp_val   = '0;
    digit_run = '0;
    addr_acc  = '0;
    grp_count = '0;
    err_seen  = 1'b0;
    port_acc  = '0;
    port_neg  = 1'b0;
  endfunction

  function automatic void flag_error();
    err_seen = 1'b1;
    ph       = PH_ERROR;
  endfunction

  // Close the current group; false when it is above the byte range
  function automatic bit close_group();
    if (grp_val > GROUP_MAX) begin
      flag_error();
      return 1'b0;
    end
    addr_acc = {addr_acc[23:0], grp_val[7:0]};
    if (grp_count < GROUPS_MAX) grp_count = grp_count + 3'd1;
    grp_val   = '0;
    digit_run = '0;
    return 1'b1;
  endfunction

  function automatic void address_char(logic [7:0] c);
    if (is_digit(c)) begin
      if (digit_run >= DIGITS_MAX) begin
        flag_error();
      end else begin
        digit_run = digit_run + 2'd1;
        grp_val   = grp_val * 10'd10 + 10'(c - CH_ZERO);
      end
    end else if (c == CH_DOT) begin
      void'(close_group());
    end else if (c == CH_COLON) begin
      if (close_group()) ph = PH_PORT_WS;
    end else if (c == CH_NUL) begin
      if (close_group()) ph = PH_ADDR_DONE;
    end else begin
      flag_error();
    end
  endfunction

  function automatic void port_digit(logic [7:0] c);
    logic [31:0] acc;
    acc      = 32'(port_acc) * 32'd10 + 32'(c - CH_ZERO);
    port_acc = acc[15:0];
    ph       = PH_PORT_DIG;
  endfunction

  // Advance the string state by one character; queue the result on the last one
  function automatic void parse_char(logic [7:0] c, logic lst);
    logic [31:0]   mask;
    parse_result_t res;
    case (ph)
      PH_START: begin
        ph = PH_GROUP;
        if (c != CH_DOT) address_char(c);
      end
      PH_GROUP: address_char(c);
      PH_PORT_WS: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          // skip leading whitespace
        end else if (c == CH_MINUS) begin
          port_neg = 1'b1;
          ph       = PH_PORT_DIG;
        end else if (c == CH_PLUS) begin
          ph = PH_PORT_DIG;
        end else if (is_digit(c)) begin
          port_digit(c);
        end else begin
          ph = PH_PORT_DONE;
        end
      end
      PH_PORT_DIG: begin
        if (is_digit(c)) port_digit(c);
        else ph = PH_PORT_DONE;
      end
      default: begin
      end
    endcase
    if (!lst) return;

    if (ph == PH_GROUP) void'(close_group());
    if (err_seen) begin
      res = '{status: 1'b1, address: 32'd0, port: 16'd0};
    end else begin
      mask = (grp_count >= GROUPS_MAX) ? 32'd0 : (32'hFFFF_FFFF << (8 * grp_count));
      res.status  = 1'b0;
      res.address = (local_addr_q & mask) | addr_acc;
      if (ph == PH_PORT_WS || ph == PH_PORT_DIG || ph == PH_PORT_DONE)
        res.port = port_neg ? (16'd0 - port_acc) : port_acc;
      else
        res.port = default_port_q;
    end
    pending_parses.push_back(res);
    restart_string();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatches < 50)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
    mismatches++;
  endtask

  // Offer one character, after a random gap if idle_gaps is set, and hold it until accepted
  task automatic send_char(input logic [7:0] c, input logic lst);
    int gap;
    gap = idle_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_char(c, lst);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_literal(input string s);
    text.delete();
    // '#' stands for NUL, which a string cannot hold
    foreach (s[i]) text.push_back((s[i] == "#") ? CH_NUL : 8'(s[i]));
    send_text();
  endtask

  // Stop offering and hold until every pending result has come out
  task automatic await_results();
    in_tvalid <= 1'b0;
    while (pending_parses.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write both registers; only called with the block idle
  task automatic set_config(input logic [31:0] addr, input logic [31:0] port_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOCAL_ADDRESS;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_index <= CFG_DEFAULT_PORT;
    cfg_wdata <= port_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    local_addr_q   = addr;
    default_port_q = port_word[15:0];
  endtask

  // Mostly well-formed addresses with random content, some noise and damage
  task automatic build_random_text();
    int    n_groups;
    int    kind;
    int    v;
    int    r;
    string num;
    text.delete();
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 6)) text.push_back(noise_char());
      return;
    end
    if ($urandom_range(0, 99) < 15) text.push_back(CH_DOT);
    n_groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    for (int g = 0; g < n_groups; g++) begin
      if (g > 0) text.push_back(CH_DOT);
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        // empty group
      end else if (kind < 9) begin
        repeat (4) text.push_back(rand_digit());
      end else begin
        v = (kind < 15) ? $urandom_range(256, 999) : $urandom_range(0, 255);
        if ($urandom_range(0, 4) == 0) num = $sformatf("%03d", v);
        else num = $sformatf("%0d", v);
        foreach (num[i]) text.push_back(8'(num[i]));
      end
    end
    if ($urandom_range(0, 99) < 50) begin
      text.push_back(CH_COLON);
      if ($urandom_range(0, 99) < 30) repeat ($urandom_range(1, 2)) text.push_back(space_char());
      r = $urandom_range(0, 9);
      if (r < 2) text.push_back(CH_MINUS);
      else if (r < 4) text.push_back(CH_PLUS);
      repeat ($urandom_range(0, 6)) text.push_back(rand_digit());
      if ($urandom_range(0, 99) < 15) text.push_back(noise_char());
    end
    if ($urandom_range(0, 99) < 10) begin
      text.push_back(CH_NUL);
      repeat ($urandom_range(0, 3)) text.push_back(noise_char());
    end
    if (text.size() == 0) text.push_back(CH_DOT);
    if ($urandom_range(0, 99) < 10) text[$urandom_range(0, text.size() - 1)] = noise_char();
  endtask

  task automatic random_batch(input int n_chars);
    int target;
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      build_random_text();
      send_text();
    end
  endtask

  // Named cases, starting on the reset values of the registers
  task automatic test_directed();
    send_literal("7");
    send_literal(":");
    await_results();
    set_config(32'hC0A8_0A05, 32'd8080);
    send_literal(".");
    send_char(CH_NUL, 1'b1);
    send_char(8'hFF, 1'b1);
    send_literal("255.0.9.1");
    send_literal("1234");
    send_literal("256");
    send_literal("..4");
    send_literal("1.2.3.4.5");
    send_literal("3#x");
    send_literal(":\t-9x");
    send_literal(":+65537");
    send_literal("1x");
    await_results();
  endtask

  // Random strings under several register settings, extremes included
  task automatic test_config_phases();
    logic [31:0] addrs[6];
    logic [31:0] ports[6];
    addrs = '{32'h0, 32'hFFFF_FFFF, $urandom(), 32'hFFFF_FFFF, 32'h0, $urandom()};
    ports = '{32'h0, 32'h0000_FFFF, $urandom(), 32'hFFFF_0000, 32'hFFFF_FFFF,
              $urandom_range(0, 65535)};
    for (int k = 0; k < 6; k++) begin
      await_results();
      set_config(addrs[k], ports[k]);
      random_batch(120);
    end
  endtask

  // Receiver holds off while strings keep coming, then drain completely
  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (12) begin
      build_random_text();
      send_text();
    end
    await_results();
  endtask

  // Back-to-back traffic on both sides
  task automatic test_steady_flow();
    idle_gaps  = 1'b0;
    ready_gaps = 1'b0;
    random_batch(200);
    await_results();
    idle_gaps  = 1'b1;
    ready_gaps = 1'b1;
  endtask

  task automatic test_random_mix();
    await_results();
    set_config($urandom(), $urandom());
    random_batch(500);
  endtask

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (ready_gaps && $urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_parses.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, out_tdata[31:0]);
      end else begin
        want = pending_parses.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_tuser));
        if (out_tdata[31:0] !== want.address)
          report_mismatch("address", want.address, out_tdata[31:0]);
        if (out_tdata[47:32] !== want.port)
          report_mismatch("port", 32'(want.port), 32'(out_tdata[47:32]));
      end
    end
  end

  // Watchdog: end the run after too long without any item accepted
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // Sequence the tests
  initial begin
    restart_string();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_phases();
    test_output_stall();
    test_steady_flow();
    test_random_mix();
    await_results();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: partial_ipv4_address_parser.f
+incdir+rtl/core
rtl/core/pia_pkg.sv
rtl/core/partial_ipv4_address_parser.sv
bench/testbench.sv
